### src/dbf_pkg.sv
// ----------------------------------------------------------------------------
// dbf_pkg: shared types and constants for the digest bloom filter
// Beat payload structs, operation and register codes, fixed field widths.
// ----------------------------------------------------------------------------
package dbf_pkg;

	localparam int OP_W       = 2;
	localparam int PCOUNT_W   = 4;
	localparam int IBITS_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int NEW_W      = 4;
	localparam int SET_W      = 21;
	localparam int CNT_W      = 32;
	localparam int DIG_WORD_W = 64;
	localparam int DIG_IN_W   = 4 * DIG_WORD_W;
	localparam int IBITS_MIN  = 3;

	localparam logic [OP_W-1:0] OP_QUERY    = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
	localparam logic [OP_W-1:0] OP_TEST_ADD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;

	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 4'd1;
	localparam logic [IBITS_W-1:0]  IBITS_RESET  = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0]       operation;
		logic [DIG_WORD_W-1:0] digest_w0;
		logic [DIG_WORD_W-1:0] digest_w1;
		logic [DIG_WORD_W-1:0] digest_w2;
		logic [DIG_WORD_W-1:0] digest_w3;
	} dbf_in_t;

	typedef struct packed {
		logic             present;
		logic [NEW_W-1:0] new_bits;
		logic             was_unique;
		logic             was_aliased;
		logic [SET_W-1:0] set_bit_total;
		logic [CNT_W-1:0] add_total;
		logic [CNT_W-1:0] unique_total;
		logic [CNT_W-1:0] aliased_total;
		logic [CNT_W-1:0] lookup_total;
	} dbf_out_t;

	typedef struct packed {
		logic [SET_W-1:0] set_bit_total;
		logic [CNT_W-1:0] add_total;
		logic [CNT_W-1:0] unique_total;
		logic [CNT_W-1:0] aliased_total;
		logic [CNT_W-1:0] lookup_total;
	} dbf_totals_t;

	typedef struct packed {
		logic bit_set;
		logic item_done;
		logic do_add;
		logic uniq;
		logic aliased;
		logic lookup;
	} dbf_stat_upd_t;

endpackage

### src/dbf_store.sv
// ----------------------------------------------------------------------------
// dbf_store: bit store memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dbf_store #(
	parameter int ROW_W     = 14,
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic [ROW_W-1:0]     rd_row,
	output logic [WORD_BITS-1:0] rd_word,
	input  logic                 wr_en,
	input  logic [ROW_W-1:0]     wr_row,
	input  logic [WORD_BITS-1:0] wr_word
);
	logic [WORD_BITS-1:0] mem [0:(1 << ROW_W)-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_word;
		end
		rd_word <= mem[rd_row];
	end

endmodule

### src/dbf_addr.sv
// ----------------------------------------------------------------------------
// dbf_addr: probe index generator
// Holds the digest and peels off one probe index per step, msb first.
// ----------------------------------------------------------------------------
module dbf_addr #(
	parameter int DIGEST_BITS    = 256,
	parameter int INDEX_BITS_MAX = 20,
	parameter int MW             = 5
) (
	input  logic                        clk,
	input  logic                        load,
	input  logic [dbf_pkg::DIG_IN_W-1:0] dig_in,
	input  logic                        step,
	input  logic [MW-1:0]               m,
	output logic [INDEX_BITS_MAX-1:0]   addr
);
	import dbf_pkg::*;

	logic [DIGEST_BITS-1:0]    dig_q;
	logic [INDEX_BITS_MAX-1:0] rev;
	logic [MW-1:0]             sh;

	// first digest bit of the probe lands in the msb
	always_comb begin
		for (int j = 0; j < INDEX_BITS_MAX; j++) begin
			rev[INDEX_BITS_MAX-1-j] = dig_q[j];
		end
		sh   = MW'(INDEX_BITS_MAX) - m;
		addr = rev >> sh;
	end

	// bits past the digest shift in as zero
	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= dig_in[DIGEST_BITS-1:0];
		end else if (step) begin
			dig_q <= dig_q >> m;
		end
	end

endmodule

### src/dbf_stats.sv
// ----------------------------------------------------------------------------
// dbf_stats: saturating statistics counters
// Set-bit count plus add, unique, aliased and lookup totals.
// ----------------------------------------------------------------------------
module dbf_stats (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dbf_pkg::dbf_stat_upd_t upd,
	output dbf_pkg::dbf_totals_t   totals
);
	import dbf_pkg::*;

	logic [SET_W-1:0] set_q;
	logic [CNT_W-1:0] add_q;
	logic [CNT_W-1:0] uniq_q;
	logic [CNT_W-1:0] alias_q;
	logic [CNT_W-1:0] look_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q   <= '0;
			add_q   <= '0;
			uniq_q  <= '0;
			alias_q <= '0;
			look_q  <= '0;
		end else begin
			if (upd.bit_set && set_q != '1) begin
				set_q <= set_q + 1'b1;
			end
			if (upd.item_done) begin
				if (upd.do_add && add_q != '1) begin
					add_q <= add_q + 1'b1;
				end
				if (upd.uniq && uniq_q != '1) begin
					uniq_q <= uniq_q + 1'b1;
				end
				if (upd.aliased && alias_q != '1) begin
					alias_q <= alias_q + 1'b1;
				end
				if (upd.lookup && look_q != '1) begin
					look_q <= look_q + 1'b1;
				end
			end
		end
	end

	assign totals.set_bit_total = set_q;
	assign totals.add_total     = add_q;
	assign totals.unique_total  = uniq_q;
	assign totals.aliased_total = alias_q;
	assign totals.lookup_total  = look_q;

endmodule

### src/digest_bloom_filter_core.sv
// ----------------------------------------------------------------------------
// digest_bloom_filter_core: bloom filter over a precomputed 256-bit digest
// Query, add and test-and-add of digests against a one-bit store.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one operation and digest per beat;
//   out_valid/out_stall/out_data return one result beat per item.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write probe_count (index 0) and
//   index_bits (index 1); cfg_ready is always high, write only while idle.
// Timing:
//   the probes of an item walk through the store one per cycle as
//   read-modify-write on its read port and its write port, with the word
//   just written forwarded to a back-to-back probe of the same row.
//   one item is in flight at a time; a finished result sits in the output
//   register so the next item is taken while it waits.
// Reset:
//   arst_n clears counters and control; the store is then swept clean one
//   64-bit row per cycle over all 2^(INDEX_BITS_MAX-6) rows (16384 by default),
//   with in_stall high until done. Config writes are taken throughout.
// Stall:
//   a held out_stall keeps the result; the following item finishes its
//   probes and then waits until the output register frees up.
// ----------------------------------------------------------------------------
module digest_bloom_filter_core #(
	parameter int INDEX_BITS_MAX = 20,
	parameter int PROBES_MAX     = 8,
	parameter int DIGEST_BITS    = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  dbf_pkg::dbf_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output dbf_pkg::dbf_out_t               out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dbf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dbf_pkg::*;

	localparam int LW        = (INDEX_BITS_MAX > 6) ? 6 : INDEX_BITS_MAX - 1;
	localparam int WORD_BITS = 1 << LW;
	localparam int RB        = INDEX_BITS_MAX - LW;
	localparam int MW        = $clog2(INDEX_BITS_MAX + 1);
	localparam int KW        = $clog2(PROBES_MAX + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0]                state_q;
	logic [PCOUNT_W-1:0]       probe_count_q;
	logic [IBITS_W-1:0]        index_bits_q;
	logic [31:0]               pc32;
	logic [31:0]               ib32;
	logic [KW-1:0]             eff_k;
	logic [MW-1:0]             eff_m;
	logic                      clr_busy_q;
	logic [RB-1:0]             clr_row_q;
	logic [OP_W-1:0]           op_q;
	logic [KW-1:0]             issue_cnt_q;
	logic                      vld_s1;
	logic [INDEX_BITS_MAX-1:0] addr_s1;
	logic                      present_q;
	logic [KW-1:0]             new_cnt_q;
	logic                      fwd_vld_q;
	logic [RB-1:0]             fwd_row_q;
	logic [WORD_BITS-1:0]      fwd_word_q;
	logic                      out_valid_q;
	dbf_out_t                  out_q;

	logic                      accept;
	logic                      issue;
	logic                      out_free;
	logic                      done_run;
	logic [INDEX_BITS_MAX-1:0] probe_addr;
	logic [RB-1:0]             row_s1;
	logic [LW-1:0]             bit_s1;
	logic [WORD_BITS-1:0]      rd_word;
	logic [WORD_BITS-1:0]      cur_word;
	logic [WORD_BITS-1:0]      set_word;
	logic                      hit_bit;
	logic                      write_op;
	logic                      new_bit;
	logic                      wr_en;
	logic [RB-1:0]             wr_row;
	logic [WORD_BITS-1:0]      wr_word;
	logic                      known_op;
	logic                      do_add;
	logic                      lookup;
	logic                      uniq;
	logic                      aliased;
	dbf_stat_upd_t             upd;
	dbf_totals_t               totals;

	// clamp the registers to their usable ranges
	always_comb begin
		pc32 = 32'(probe_count_q);
		ib32 = 32'(index_bits_q);
		if (pc32 == 32'd0) begin
			eff_k = KW'(1);
		end else if (pc32 > 32'(PROBES_MAX)) begin
			eff_k = KW'(PROBES_MAX);
		end else begin
			eff_k = KW'(pc32);
		end
		if (ib32 < 32'(IBITS_MIN)) begin
			eff_m = MW'(IBITS_MIN);
		end else if (ib32 > 32'(INDEX_BITS_MAX)) begin
			eff_m = MW'(INDEX_BITS_MAX);
		end else begin
			eff_m = MW'(ib32);
		end
	end

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || clr_busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign issue    = (state_q == ST_RUN) && (issue_cnt_q != eff_k);
	assign done_run = (state_q == ST_RUN) && (issue_cnt_q == eff_k) && !vld_s1;
	assign write_op = (op_q == OP_ADD) || (op_q == OP_TEST_ADD);

	assign row_s1 = addr_s1[INDEX_BITS_MAX-1:LW];
	assign bit_s1 = addr_s1[LW-1:0];

	// the row written last cycle was read before the write landed
	assign cur_word = (fwd_vld_q && fwd_row_q == row_s1) ? fwd_word_q : rd_word;
	assign hit_bit  = cur_word[bit_s1];
	assign set_word = cur_word | (WORD_BITS'(1) << bit_s1);
	assign new_bit  = vld_s1 && write_op && !hit_bit;

	assign wr_en   = clr_busy_q || new_bit;
	assign wr_row  = clr_busy_q ? clr_row_q : row_s1;
	assign wr_word = clr_busy_q ? '0 : set_word;

	assign known_op = (op_q == OP_QUERY) || (op_q == OP_ADD) || (op_q == OP_TEST_ADD);
	assign do_add   = (op_q == OP_ADD) || ((op_q == OP_TEST_ADD) && !present_q);
	assign lookup   = (op_q == OP_QUERY) || (op_q == OP_TEST_ADD);
	assign uniq     = do_add && (new_cnt_q == eff_k);
	assign aliased  = do_add && (new_cnt_q == '0);

	assign upd.bit_set   = new_bit;
	assign upd.item_done = (state_q == ST_FIN);
	assign upd.do_add    = do_add;
	assign upd.uniq      = uniq;
	assign upd.aliased   = aliased;
	assign upd.lookup    = lookup;

	dbf_addr #(
		.DIGEST_BITS   (DIGEST_BITS),
		.INDEX_BITS_MAX(INDEX_BITS_MAX),
		.MW            (MW)
	) u_addr (
		.clk   (clk),
		.load  (accept),
		.dig_in({in_data.digest_w3, in_data.digest_w2, in_data.digest_w1, in_data.digest_w0}),
		.step  (issue),
		.m     (eff_m),
		.addr  (probe_addr)
	);

	dbf_store #(
		.ROW_W    (RB),
		.WORD_BITS(WORD_BITS)
	) u_store (
		.clk    (clk),
		.rd_row (probe_addr[INDEX_BITS_MAX-1:LW]),
		.rd_word(rd_word),
		.wr_en  (wr_en),
		.wr_row (wr_row),
		.wr_word(wr_word)
	);

	dbf_stats u_stats (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (upd),
		.totals(totals)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			probe_count_q <= PCOUNT_RESET;
			index_bits_q  <= IBITS_RESET;
			clr_busy_q    <= 1'b1;
			clr_row_q     <= '0;
			op_q          <= OP_QUERY;
			issue_cnt_q   <= '0;
			vld_s1        <= 1'b0;
			present_q     <= 1'b0;
			new_cnt_q     <= '0;
			fwd_vld_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_PROBE_COUNT: probe_count_q <= cfg_data[PCOUNT_W-1:0];
					CFG_INDEX_BITS:  index_bits_q  <= cfg_data[IBITS_W-1:0];
					default: ;
				endcase
			end

			// a result loaded this cycle takes over the slot below
			if (out_valid_q && !out_stall && state_q != ST_LOAD) begin
				out_valid_q <= 1'b0;
			end

			vld_s1 <= issue;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q        <= in_data.operation;
						issue_cnt_q <= '0;
						present_q   <= 1'b1;
						new_cnt_q   <= '0;
						fwd_vld_q   <= 1'b0;
						state_q     <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (vld_s1) begin
						present_q  <= present_q & hit_bit;
						fwd_vld_q  <= 1'b1;
						fwd_row_q  <= row_s1;
						fwd_word_q <= new_bit ? set_word : cur_word;
						if (new_bit) begin
							new_cnt_q <= new_cnt_q + 1'b1;
						end
					end
					if (done_run) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= probe_addr;
		end
		if (state_q == ST_LOAD && out_free) begin
			out_q.present       <= known_op && present_q;
			out_q.new_bits      <= NEW_W'(new_cnt_q);
			out_q.was_unique    <= uniq;
			out_q.was_aliased   <= aliased;
			out_q.set_bit_total <= totals.set_bit_total;
			out_q.add_total     <= totals.add_total;
			out_q.unique_total  <= totals.unique_total;
			out_q.aliased_total <= totals.aliased_total;
			out_q.lookup_total  <= totals.lookup_total;
		end
	end

endmodule

### tb/sv/digest_bloom_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digest_bloom_filter_core_tb: self-checking bench for the digest bloom filter
// Drives query, add, test-and-add and reserved beats under random idling and a
// long output hold-off, predicts every result beat from a local copy of the bit
// store and counters, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module digest_bloom_filter_core_tb;
	import dbf_pkg::*;

	localparam int INDEX_BITS_MAX = 20;
	localparam int PROBES_MAX     = 8;
	localparam int DIGEST_BITS    = 256;
	localparam int STORE_DEPTH    = 1 << INDEX_BITS_MAX;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int HOLD_CYCLES    = 400;
	localparam int POOL_DEPTH     = 64;
	localparam int RANDOM_PER_CFG = 150;

	localparam logic [OP_W-1:0]      OP_RESERVED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	dbf_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	dbf_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// local copy of the filter state
	bit                    filter_bits [STORE_DEPTH];
	dbf_totals_t           totals          = '0;
	logic [PCOUNT_W-1:0]   probe_count_reg = PCOUNT_RESET;
	logic [IBITS_W-1:0]    index_bits_reg  = IBITS_RESET;

	dbf_out_t              awaited_results [$];
	logic [DIG_IN_W-1:0]   added_digests [$];
	int                    errors        = 0;
	int                    snd_idle      = 0;
	int                    rcv_idle      = 0;
	int                    hold_requests = 0;
	int                    hold_seen     = 0;
	int                    hold_left     = 0;
	int                    quiet_cycles  = 0;

	digest_bloom_filter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned probe_index(logic [DIG_IN_W-1:0] dig, int probe, int width);
		int unsigned addr;
		int pos;
		addr = 0;
		// first digest bit read lands in the msb of the index
		for (int j = 0; j < width; j++) begin
			pos = probe * width + j;
			if (pos < DIGEST_BITS)
				addr = (addr << 1) | 32'(dig[pos]);
			else
				addr = addr << 1;
		end
		return addr % STORE_DEPTH;
	endfunction

	function automatic dbf_out_t predict_filter(dbf_in_t item);
		dbf_out_t res;
		logic [DIG_IN_W-1:0] dig;
		int k;
		int m;
		int added;
		int unsigned addr;
		bit hit;
		bit do_add;
		dig = {item.digest_w3, item.digest_w2, item.digest_w1, item.digest_w0};
		k = (probe_count_reg == 0) ? 1 :
			(probe_count_reg > PROBES_MAX) ? PROBES_MAX : int'(probe_count_reg);
		m = (index_bits_reg < IBITS_MIN) ? IBITS_MIN :
			(index_bits_reg > INDEX_BITS_MAX) ? INDEX_BITS_MAX : int'(index_bits_reg);
		res    = '0;
		hit    = 1'b0;
		do_add = 1'b0;
		added  = 0;
		if (item.operation != OP_RESERVED) begin
			hit = 1'b1;
			for (int i = 0; i < k; i++)
				if (!filter_bits[probe_index(dig, i, m)])
					hit = 1'b0;
			if (item.operation != OP_ADD && totals.lookup_total != '1)
				totals.lookup_total += 1;
			do_add = (item.operation == OP_ADD) || (item.operation == OP_TEST_ADD && !hit);
		end
		if (do_add) begin
			// a repeated address sees the bit an earlier probe just set
			for (int i = 0; i < k; i++) begin
				addr = probe_index(dig, i, m);
				if (!filter_bits[addr]) begin
					filter_bits[addr] = 1'b1;
					added++;
					if (totals.set_bit_total != '1)
						totals.set_bit_total += 1;
				end
			end
			res.was_unique  = (added == k);
			res.was_aliased = (added == 0);
			if (res.was_unique && totals.unique_total != '1)
				totals.unique_total += 1;
			if (res.was_aliased && totals.aliased_total != '1)
				totals.aliased_total += 1;
			if (totals.add_total != '1)
				totals.add_total += 1;
		end
		res.present       = hit;
		res.new_bits      = NEW_W'(added);
		res.set_bit_total = totals.set_bit_total;
		res.add_total     = totals.add_total;
		res.unique_total  = totals.unique_total;
		res.aliased_total = totals.aliased_total;
		res.lookup_total  = totals.lookup_total;
		return res;
	endfunction

	function automatic dbf_in_t pack_item(logic [OP_W-1:0] op, logic [DIG_IN_W-1:0] dig);
		dbf_in_t item;
		item.operation = op;
		{item.digest_w3, item.digest_w2, item.digest_w1, item.digest_w0} = dig;
		return item;
	endfunction

	function automatic dbf_in_t random_item();
		logic [DIG_IN_W-1:0] dig;
		logic [OP_W-1:0] op;
		int pick;
		pick = $urandom_range(99);
		op = (pick < 5) ? OP_RESERVED : (pick < 35) ? OP_QUERY :
			(pick < 65) ? OP_ADD : OP_TEST_ADD;
		for (int w = 0; w < DIG_IN_W / 32; w++)
			dig[w * 32 +: 32] = $urandom;
		pick = $urandom_range(99);
		if (pick < 40 && added_digests.size() != 0)
			dig = added_digests[$urandom_range(added_digests.size() - 1)];
		else if (pick < 45)
			dig = '0;
		else if (pick < 50)
			dig = '1;
		else if (pick < 60) begin
			// sparse digests pile probes onto the same few addresses
			dig = dig & (dig >> 7);
			dig = dig & (dig >> 13);
		end
		return pack_item(op, dig);
	endfunction

	task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic send_item(dbf_in_t item);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall !== 1'b0);
		awaited_results.push_back(predict_filter(item));
		if (item.operation == OP_ADD || item.operation == OP_TEST_ADD) begin
			added_digests.push_back({item.digest_w3, item.digest_w2,
				item.digest_w1, item.digest_w0});
			if (added_digests.size() > POOL_DEPTH)
				void'(added_digests.pop_front());
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_PROBE_COUNT: begin
				probe_count_reg = val[PCOUNT_W-1:0];
			end
			CFG_INDEX_BITS: begin
				index_bits_reg = val[IBITS_W-1:0];
			end
			default: ;
		endcase
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] pcount, logic [CFG_DATA_W-1:0] ibits);
		drain_results();
		write_reg(CFG_PROBE_COUNT, pcount);
		write_reg(CFG_INDEX_BITS, ibits);
		cfg_valid <= 1'b0;
	endtask

	// reset config: one probe over a full 20-bit index
	task automatic test_basic_ops();
		send_item(pack_item(OP_QUERY, '0));
		send_item(pack_item(OP_ADD, '0));
		send_item(pack_item(OP_QUERY, '0));
		send_item(pack_item(OP_TEST_ADD, '0));
		send_item(pack_item(OP_ADD, '0));
		send_item(pack_item(OP_TEST_ADD, '1));
		send_item(pack_item(OP_QUERY, '1));
		send_item(pack_item(OP_RESERVED, '1));
	endtask

	task automatic test_probe_patterns();
		logic [DIG_IN_W-1:0] rep;
		rep = '0;
		// every probe decodes to the same address
		for (int i = 0; i < PROBES_MAX; i++)
			rep[i * INDEX_BITS_MAX + INDEX_BITS_MAX - 1] = 1'b1;
		set_config(PROBES_MAX, INDEX_BITS_MAX);
		send_item(pack_item(OP_ADD, rep));
		send_item(pack_item(OP_ADD, '1));
		send_item(pack_item(OP_TEST_ADD, '0));
		send_item(pack_item(OP_QUERY, {{DIG_WORD_W{1'b1}}, {(3 * DIG_WORD_W){1'b0}}}));
		send_item(random_item());
	endtask

	task automatic test_register_limits();
		set_config('0, '0);
		repeat (3) send_item(random_item());
		set_config('1, '1);
		repeat (3) send_item(random_item());
		set_config(5'd9, 5'd2);
		repeat (3) send_item(random_item());
		drain_results();
		write_reg(CFG_UNUSED_A, '1);
		write_reg(CFG_UNUSED_B, '0);
		cfg_valid <= 1'b0;
		repeat (2) send_item(random_item());
	endtask

	task automatic test_random_traffic();
		int pc_tab [9] = '{8, 1, 4, 15, 3, 0, 6, 8, 2};
		int ib_tab [9] = '{3, 20, 10, 31, 4, 0, 16, 20, 7};
		for (int mode = 0; mode < 3; mode++) begin
			snd_idle = (mode == 0) ? 33 : (mode == 1) ? 72 : 0;
			rcv_idle = (mode == 0) ? 72 : (mode == 1) ? 33 : 0;
			for (int s = 0; s < 4; s++) begin
				if (s == 3)
					set_config(CFG_DATA_W'($urandom_range(31)),
						CFG_DATA_W'($urandom_range(31)));
				else
					set_config(CFG_DATA_W'(pc_tab[mode * 3 + s]),
						CFG_DATA_W'(ib_tab[mode * 3 + s]));
				repeat (RANDOM_PER_CFG) send_item(random_item());
			end
		end
	endtask

	// receiver holds off while beats keep coming until the input stalls
	task automatic test_backpressure();
		set_config(5'd4, 5'd12);
		snd_idle = 0;
		rcv_idle = 0;
		hold_requests++;
		@(posedge clk);
		repeat (12) send_item(random_item());
	endtask

	always @(posedge clk) begin : receiver
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	always @(posedge clk) begin : result_check
		dbf_out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got %0h",
					$time, out_data);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				check_field("present", CNT_W'(want.present), CNT_W'(out_data.present));
				check_field("new_bits", CNT_W'(want.new_bits), CNT_W'(out_data.new_bits));
				check_field("was_unique", CNT_W'(want.was_unique),
					CNT_W'(out_data.was_unique));
				check_field("was_aliased", CNT_W'(want.was_aliased),
					CNT_W'(out_data.was_aliased));
				check_field("set_bit_total", CNT_W'(want.set_bit_total),
					CNT_W'(out_data.set_bit_total));
				check_field("add_total", want.add_total, out_data.add_total);
				check_field("unique_total", want.unique_total, out_data.unique_total);
				check_field("aliased_total", want.aliased_total, out_data.aliased_total);
				check_field("lookup_total", want.lookup_total, out_data.lookup_total);
			end
		end
	end

	// store sweep after reset keeps the input stalled for a long stretch
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
			(cfg_valid && cfg_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("digest_bloom_filter_core_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle = 33;
		rcv_idle = 72;
		test_basic_ops();
		test_probe_patterns();
		test_register_limits();
		test_random_traffic();
		test_backpressure();
		drain_results();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("digest_bloom_filter_core_tb: PASS");
		else
			$display("digest_bloom_filter_core_tb: FAIL");
		$finish;
	end

endmodule
